@@ hw/rtl/dftd_pkg.sv @@
// shared constants, types and helper functions of the damped feedback delay
`default_nettype none

package dftd_pkg;

    // store geometry
    localparam int DELAY_DEPTH  = 131072;
    localparam int SAMPLE_WIDTH = 24;
    localparam int ADDR_W       = $clog2(DELAY_DEPTH);
    // read position in samples with 16 fraction bits
    localparam int R_W          = ADDR_W + 17;

    // arithmetic widths
    localparam int CW   = ((SAMPLE_WIDTH > 24) ? SAMPLE_WIDTH : 24) + 2;
    localparam int PW   = CW + 18;
    localparam int SUMW = PW + 1;

    // delay time path
    localparam int T5_W    = 20;
    localparam int T5_MIN  = 1638;
    localparam int T5_MAX  = 622592;
    localparam int PRD_W   = 37;
    // floor(v / 5) = (v * DIV5_M) >> DIV5_SH, exact for v below 2^20
    localparam int              DIV5_SH = 23;
    localparam logic [20:0]     DIV5_M  = 21'd1677722;
    localparam logic [PRD_W-1:0] DLY_MAX = PRD_W'(DELAY_DEPTH - 2) << 16;

    // soft clip
    localparam int ONE   = 1 << 20;
    localparam int NUM_W = 48;
    localparam int DEN_W = 27;
    localparam int QUO_W = 21;

    // configuration port
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_BASE_DELAY = 3'd0,
        REG_FEEDBACK   = 3'd1,
        REG_DAMPING    = 3'd2,
        REG_WET_MIX    = 3'd3,
        REG_SAMPLE_RATE = 3'd4
    } reg_idx_t;

    localparam logic [16:0] BASE_RST = 17'd19661;
    localparam logic [15:0] FB_RST   = 16'd26214;
    localparam logic [15:0] DAMP_RST = 16'd26214;
    localparam logic [16:0] MIX_RST  = 17'd22938;
    localparam logic [16:0] SR_RST   = 17'd48000;

    localparam logic [16:0] BASE_LO = 17'd655;
    localparam logic [16:0] BASE_HI = 17'd117965;
    localparam logic [15:0] FB_HI   = 16'd62259;
    localparam logic [15:0] DAMP_HI = 16'd58982;
    localparam logic [16:0] MIX_HI  = 17'd65536;

    // clamped settings seen by the datapath
    typedef struct packed {
        logic [16:0] base;
        logic [15:0] fb;
        logic [15:0] damp;
        logic [16:0] mix;
        logic [16:0] sr;
    } cfg_t;

    // round half up, divide by 2^16
    function automatic logic signed [SUMW-1:0] rsh16(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] t;
        t = v + SUMW'(32768);
        return t >>> 16;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [SUMW-1:0] v);
        logic signed [23:0] r;
        if (v > SUMW'(24'sh7FFFFF))
            r = 24'sh7FFFFF;
        else if (v < -SUMW'(24'sh7FFFFF) - SUMW'(1))
            r = -24'sh7FFFFF - 24'sd1;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sw(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] r;
        hi = (SUMW'(1) <<< (SAMPLE_WIDTH - 1)) - SUMW'(1);
        lo = -hi - SUMW'(1);
        if (v > hi)
            r = hi[SAMPLE_WIDTH-1:0];
        else if (v < lo)
            r = lo[SAMPLE_WIDTH-1:0];
        else
            r = v[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dftd_regs.sv @@
// configuration registers with range clamps
`default_nettype none

module dftd_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dftd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output dftd_pkg::cfg_t                    cfg
);
    import dftd_pkg::*;

    logic [16:0] base_reg;
    logic [15:0] fb_reg;
    logic [15:0] damp_reg;
    logic [16:0] mix_reg;
    logic [16:0] sr_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RST;
            fb_reg   <= FB_RST;
            damp_reg <= DAMP_RST;
            mix_reg  <= MIX_RST;
            sr_reg   <= SR_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BASE_DELAY:  base_reg <= pwdata[16:0];
                REG_FEEDBACK:    fb_reg   <= pwdata[15:0];
                REG_DAMPING:     damp_reg <= pwdata[15:0];
                REG_WET_MIX:     mix_reg  <= pwdata[16:0];
                REG_SAMPLE_RATE: sr_reg   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BASE_DELAY:  prdata = {15'd0, base_reg};
            REG_FEEDBACK:    prdata = {16'd0, fb_reg};
            REG_DAMPING:     prdata = {16'd0, damp_reg};
            REG_WET_MIX:     prdata = {15'd0, mix_reg};
            REG_SAMPLE_RATE: prdata = {15'd0, sr_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.base = (base_reg < BASE_LO) ? BASE_LO : ((base_reg > BASE_HI) ? BASE_HI : base_reg);
        cfg.fb   = (fb_reg > FB_HI) ? FB_HI : fb_reg;
        cfg.damp = (damp_reg > DAMP_HI) ? DAMP_HI : damp_reg;
        cfg.mix  = (mix_reg > MIX_HI) ? MIX_HI : mix_reg;
        cfg.sr   = sr_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/dftd_ram.sv @@
// generic simple dual-port ram, registered read
`default_nettype none

module dftd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/dftd_div.sv @@
// bit-serial restoring divider for the soft clip, rounds half up
`default_nettype none

module dftd_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dftd_pkg::NUM_W-1:0] num,
    input  wire logic [dftd_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic      [dftd_pkg::QUO_W-1:0] quo
);
    import dftd_pkg::*;

    logic [DEN_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   low_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [NUM_W:0]     n_init;
    logic [DEN_W:0]     trial;
    logic               ge;

    // n = num + den/2; the top part is below den since the quotient fits
    assign n_init = {1'b0, num} + (NUM_W + 1)'(den >> 1);
    assign trial  = {rem_reg, low_reg[QUO_W-1]};
    assign ge     = trial >= {1'b0, den_reg};
    assign done   = done_reg;
    assign quo    = low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= n_init[NUM_W-1:QUO_W];
            low_reg <= n_init[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/damped_feedback_tape_delay.sv @@
// top level: feedback delay line with damping lowpass, soft clip and dry/wet mix
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tdata: audio_in[23:0], time_cv[39:24]
//   m_axis    out  tvalid/tready             tdata: audio_out[23:0]
//   apb       in   psel/penable/pwrite       5 registers at byte address 4*index
//
// one item at a time: the accept cycle, 17 steps (the divide by five of the delay is
// a reciprocal multiply spread over three of them), the serial divide in the soft
// clip and the store write; the result is registered in the lowpass state update
// step, once the output register is free.
// reset clears control state; store entries not yet written read as zero
// through the write position and a wrap flag, so no clearing pass is needed.
// a result that is not taken stalls the sequencer just before the lowpass
// state update; a new item is accepted while the last result still waits.
`default_nettype none

module damped_feedback_tape_delay (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [39:0]                  s_axis_tdata,  // audio_in, time_cv
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [23:0]                  m_axis_tdata,  // audio_out
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dftd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import dftd_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE = 20'h00001,
        ST_T5   = 20'h00002,
        ST_MUL  = 20'h00004,
        ST_DIV5 = 20'h00008,
        ST_DLY  = 20'h00010,
        ST_ADR  = 20'h00020,
        ST_RDA  = 20'h00040,
        ST_RDB  = 20'h00080,
        ST_CAPB = 20'h00100,
        ST_INT  = 20'h00200,
        ST_DEL  = 20'h00400,
        ST_LPM  = 20'h00800,
        ST_LPS  = 20'h01000,
        ST_FB   = 20'h02000,
        ST_XABS = 20'h04000,
        ST_SQ   = 20'h08000,
        ST_NUM  = 20'h10000,
        ST_DIVS = 20'h20000,
        ST_DIVW = 20'h40000,
        ST_WR   = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    cfg_t   cfg;

    // item and datapath registers
    logic signed [23:0]             dry_reg;
    logic signed [15:0]             cv_reg;
    logic [T5_W-1:0]                t5_reg;
    logic [16:0]                    q5_reg;
    logic [PRD_W-1:0]               hi_reg;
    logic [19:0]                    y_reg;
    logic [PRD_W-1:0]               dly_reg;
    logic [ADDR_W-1:0]              idx1_reg, idx2_reg;
    logic [15:0]                    frac_reg;
    logic                           vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] sa_reg, sb_reg, del_reg;
    logic signed [PW-1:0]           dp_reg, p1_reg, p2_reg, p3_reg, xp_reg;
    logic                           neg_reg, big_reg;
    logic [21:0]                    ax_reg;
    logic [43:0]                    sq_reg;
    logic [NUM_W-1:0]               num_reg;
    logic [DEN_W-1:0]               den_reg;

    // control state
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              wrap_reg, wrap_next;
    logic signed [23:0] lp_reg, lp_next;
    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_data_reg, m_data_next;

    // combinational datapath
    logic [T5_W-1:0]         base5;
    logic signed [22:0]      t5s;
    logic [T5_W-1:0]         t5c;
    logic [40:0]             q5m;
    logic [16:0]             q5;
    logic [2:0]              r5;
    logic [PRD_W-1:0]        hi;
    logic [19:0]             y;
    logic [40:0]             y5m;
    logic [PRD_W-1:0]        dsum;
    logic [PRD_W-1:0]        dly_sat;
    logic [R_W-1:0]          pos, dlyt, rpos;
    logic [ADDR_W:0]         idx1w;
    logic [ADDR_W-1:0]       idx1, idx2;
    logic [ADDR_W-1:0]       raddr;
    logic [SAMPLE_WIDTH-1:0] rdata;
    logic signed [SAMPLE_WIDTH-1:0] rdm;
    logic                    rd_vld;
    logic signed [SAMPLE_WIDTH:0] diffab;
    logic signed [PW-1:0]    dp, p1, p2, p3, xp;
    logic signed [SUMW-1:0]  del_w, lp_w, o_w, x_w, wsum;
    logic signed [23:0]      x24;
    logic [23:0]             ax24;
    logic [43:0]             sq;
    logic [23:0]             a2;
    logic [25:0]             mterm;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quo;
    logic [QUO_W-1:0]        rv;
    logic signed [QUO_W:0]   srv;
    logic signed [SAMPLE_WIDTH-1:0] wr_val;
    logic                    ram_we;
    logic                    out_load;

    dftd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dftd_ram #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_WIDTH),
        .AW    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (wr_val),
        .raddr (raddr),
        .rdata (rdata)
    );

    dftd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIVS),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign ram_we        = (state_reg == ST_WR);
    assign out_load      = (state_reg == ST_LPS) && (!m_valid_reg || m_axis_tready);

    // effective delay time in 1/327680 s
    always_comb
    begin
        base5 = T5_W'(cfg.base) * T5_W'(5);
        t5s   = 23'($signed({3'b000, base5})) + (23'(cv_reg) <<< 5);
        if (t5s < 23'sd1638)
            t5c = T5_W'(T5_MIN);
        else if (t5s > 23'sd622592)
            t5c = T5_W'(T5_MAX);
        else
            t5c = t5s[T5_W-1:0];
    end

    // t5*sr/5 as (t5/5)*sr + (t5%5)*sr/5, each divide a reciprocal multiply
    always_comb
    begin
        q5m     = 41'(t5_reg) * 41'(DIV5_M);
        q5      = 17'(q5m >> DIV5_SH);
        r5      = 3'(t5_reg - (T5_W'(q5_reg) * T5_W'(5)));
        hi      = PRD_W'(q5_reg) * PRD_W'(cfg.sr);
        y       = 20'(r5) * 20'(cfg.sr);
        y5m     = 41'(y_reg) * 41'(DIV5_M);
        dsum    = hi_reg + PRD_W'(y5m >> DIV5_SH);
        dly_sat = (dsum > DLY_MAX) ? DLY_MAX : dsum;
    end

    // read position behind the write position
    always_comb
    begin
        pos   = {1'b0, wp_reg, 16'h0000};
        dlyt  = dly_reg[R_W-1:0];
        rpos  = (pos >= dlyt) ? pos - dlyt : pos + (R_W'(DELAY_DEPTH) << 16) - dlyt;
        idx1w = rpos[R_W-1:16];
        idx1  = (idx1w >= (ADDR_W + 1)'(DELAY_DEPTH)) ? '0 : idx1w[ADDR_W-1:0];
        idx2  = (idx1 == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : idx1 + ADDR_W'(1);
    end

    // entries never written read as zero
    assign raddr  = (state_reg == ST_RDA) ? idx1_reg : idx2_reg;
    assign rd_vld = wrap_reg || (raddr < wp_reg);
    assign rdm    = vld_reg ? $signed(rdata) : '0;

    // interpolation, lowpass and mix
    always_comb
    begin
        diffab = (SAMPLE_WIDTH + 1)'(sb_reg) - (SAMPLE_WIDTH + 1)'(sa_reg);
        dp     = PW'(diffab) * PW'($signed({1'b0, frac_reg}));
        del_w  = SUMW'(sa_reg) + rsh16(SUMW'(dp_reg));
        p1     = PW'(del_reg) * PW'($signed({1'b0, 17'd65536 - {1'b0, cfg.damp}}));
        p2     = PW'(lp_reg) * PW'($signed({1'b0, cfg.damp}));
        p3     = PW'(CW'(del_reg) - CW'(dry_reg)) * PW'($signed({1'b0, cfg.mix}));
        lp_w   = rsh16(SUMW'(p1_reg) + SUMW'(p2_reg));
        o_w    = SUMW'(dry_reg) + rsh16(SUMW'(p3_reg));
        xp     = PW'(lp_reg) * PW'($signed({1'b0, cfg.fb}));
    end

    // soft clip x*(27+x^2)/(27+9x^2)
    always_comb
    begin
        x_w   = rsh16(SUMW'(xp_reg));
        x24   = x_w[23:0];
        ax24  = x24[23] ? 24'(-x24) : x24;
        sq    = 44'(ax_reg) * 44'(ax_reg);
        a2    = 24'((45'(sq_reg) + 45'(1 << 19)) >> 20);
        mterm = 26'(27 * ONE) + 26'(a2);
        num   = NUM_W'(ax_reg) * NUM_W'(mterm);
        den   = DEN_W'(27 * ONE) + DEN_W'(a2) * DEN_W'(9);
        rv    = big_reg ? QUO_W'(ONE) : div_quo;
        srv   = neg_reg ? -$signed({1'b0, rv}) : $signed({1'b0, rv});
        wsum  = SUMW'(dry_reg) + SUMW'(srv);
        wr_val = sat_sw(wsum);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_T5;
            ST_T5:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV5;
            ST_DIV5: state_next = ST_DLY;
            ST_DLY:  state_next = ST_ADR;
            ST_ADR:  state_next = ST_RDA;
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_CAPB;
            ST_CAPB: state_next = ST_INT;
            ST_INT:  state_next = ST_DEL;
            ST_DEL:  state_next = ST_LPM;
            ST_LPM:  state_next = ST_LPS;
            ST_LPS:  if (out_load) state_next = ST_FB;
            ST_FB:   state_next = ST_XABS;
            ST_XABS: state_next = ST_SQ;
            ST_SQ:   state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: if (div_done) state_next = ST_WR;
            ST_WR:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control state updates
    always_comb
    begin
        wp_next      = wp_reg;
        wrap_next    = wrap_reg;
        lp_next      = lp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;
        if (out_load)
        begin
            lp_next      = sat24(lp_w);
            m_valid_next = 1'b1;
            m_data_next  = sat24(o_w);
        end
        if (state_reg == ST_WR)
        begin
            if (wp_reg == ADDR_W'(DELAY_DEPTH - 1))
            begin
                wp_next   = '0;
                wrap_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            wrap_reg    <= 1'b0;
            lp_reg      <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            wrap_reg    <= wrap_next;
            lp_reg      <= lp_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

    // payload registers, loaded by step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dry_reg <= $signed(s_axis_tdata[23:0]);
                cv_reg  <= $signed(s_axis_tdata[39:24]);
            end
            ST_T5:   t5_reg <= t5c;
            ST_MUL:  q5_reg <= q5;
            ST_DIV5:
            begin
                hi_reg <= hi;
                y_reg  <= y;
            end
            ST_DLY:  dly_reg <= dly_sat;
            ST_ADR:
            begin
                idx1_reg <= idx1;
                idx2_reg <= idx2;
                frac_reg <= rpos[15:0];
            end
            ST_RDA:  vld_reg <= rd_vld;
            ST_RDB:
            begin
                sa_reg  <= rdm;
                vld_reg <= rd_vld;
            end
            ST_CAPB: sb_reg <= rdm;
            ST_INT:  dp_reg <= dp;
            ST_DEL:  del_reg <= del_w[SAMPLE_WIDTH-1:0];
            ST_LPM:
            begin
                p1_reg <= p1;
                p2_reg <= p2;
                p3_reg <= p3;
            end
            ST_FB:   xp_reg <= xp;
            ST_XABS:
            begin
                neg_reg <= x24[23];
                big_reg <= ax24 >= 24'(3 * ONE);
                ax_reg  <= ax24[21:0];
            end
            ST_SQ:   sq_reg <= sq;
            ST_NUM:
            begin
                num_reg <= num;
                den_reg <= den;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
